@@ design/psg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and the reciprocal table of the proximity gate.
// ----------------------------------------------------------------------------
package psg_pkg;

    // field widths
    localparam int VEL_W   = 16;
    localparam int RANGE_W = 17;
    localparam int THR_W   = 16;
    localparam int SUM_W   = 19;
    localparam int DIR_W   = 2;

    // command history
    localparam int HIST_DEPTH = 5;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);

    // scan indexing
    localparam int MAX_SCAN_POINTS = 1024;
    localparam int SCAN_IDX_W      = $clog2(MAX_SCAN_POINTS);
    localparam int SCAN_N_W        = SCAN_IDX_W + 1;
    localparam int SECTOR_W        = SCAN_N_W + 1;

    // range handling
    localparam logic [RANGE_W-1:0] NO_RANGE    = 17'd100000;
    localparam logic [RANGE_W-1:0] EXIT_MARGIN = 17'd500;
    localparam logic signed [VEL_W-1:0] REVERSE_SPEED = -16'sd500;

    // sector codes
    localparam logic [DIR_W-1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_FRONT   = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT    = 2'd3;

    // result kinds
    localparam logic KIND_DRIVE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // input word kinds
    localparam logic CMD_USER  = 1'b0;
    localparam logic CMD_RANGE = 1'b1;

    // averaging by reciprocal multiply
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int ABS_W       = SUM_W - 1;
    localparam int PROD_W      = ABS_W + RECIP_W;
    localparam int QUOT_W      = VEL_W + 1;

    // configuration registers
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_HIGH = 2'd2;
    localparam logic [THR_W-1:0]   THRESHOLD_RESET  = 16'd1000;
    localparam logic [RANGE_W-1:0] RANGE_LOW_RESET  = 17'd100;
    localparam logic [RANGE_W-1:0] RANGE_HIGH_RESET = 17'd30000;

    // job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // one classified job from the front to the back
    typedef struct packed {
        logic                        kind;
        logic                        two;
        logic signed [VEL_W-1:0]     drive_lin;
        logic signed [VEL_W-1:0]     drive_ang;
        logic [RANGE_W-1:0]          near_mm;
        logic [DIR_W-1:0]            dir;
        logic [THR_W-1:0]            thr;
        logic                        backup;
        logic signed [SUM_W-1:0]     sum_lin;
        logic signed [SUM_W-1:0]     sum_ang;
        logic [HIST_CNT_W-1:0]       count;
    } job_t;

    // one result word
    typedef struct packed {
        logic                        kind;
        logic signed [VEL_W-1:0]     drive_linear;
        logic signed [VEL_W-1:0]     drive_angular;
        logic                        is_override;
        logic [RANGE_W-1:0]          near_distance;
        logic [DIR_W-1:0]            direction;
        logic [THR_W-1:0]            threshold_now;
        logic                        backup_active;
        logic                        avg_valid;
        logic signed [VEL_W-1:0]     mean_linear;
        logic signed [VEL_W-1:0]     mean_angular;
        logic                        last;
    } result_t;

    // config values seen by the front
    typedef struct packed {
        logic [THR_W-1:0]   thr;
        logic [RANGE_W-1:0] low;
        logic [RANGE_W-1:0] high;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CALC,
        BK_FIRST,
        BK_SECOND
    } back_state_t;

    // ceil(2^RECIP_SHIFT / c), exact for magnitudes below 2^18
    function automatic logic [RECIP_W-1:0] recip(input logic [HIST_CNT_W-1:0] c);
        logic [RECIP_W-1:0] r;
        case (c)
            3'd1:    r = 23'd4194304;
            3'd2:    r = 23'd2097152;
            3'd3:    r = 23'd1398102;
            3'd4:    r = 23'd1048576;
            3'd5:    r = 23'd838861;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/psg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psg_front
// Takes input words, keeps command history and scan minimum, decides backup
// mode and pushes one classified job per word that yields results.
// ----------------------------------------------------------------------------
module psg_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic                              cmd,
    input  wire logic signed [psg_pkg::VEL_W-1:0]  linear_vel,
    input  wire logic signed [psg_pkg::VEL_W-1:0]  angular_vel,
    input  wire logic [psg_pkg::RANGE_W-1:0]       range_sample,
    input  wire logic                              sample_last,
    input  wire psg_pkg::cfg_t                     cfg,
    output psg_pkg::job_t                          job,
    output logic                                   job_push
);

    // history store, oldest entry read before it is overwritten
    logic signed [psg_pkg::VEL_W-1:0] hist_lin_reg [psg_pkg::HIST_DEPTH];
    logic signed [psg_pkg::VEL_W-1:0] hist_ang_reg [psg_pkg::HIST_DEPTH];

    logic [psg_pkg::HIST_CNT_W-1:0]   hist_count_reg, hist_count_next;
    logic [psg_pkg::HIST_IDX_W-1:0]   hist_pos_reg, hist_pos_next;
    logic signed [psg_pkg::SUM_W-1:0] sum_lin_reg, sum_lin_next;
    logic signed [psg_pkg::SUM_W-1:0] sum_ang_reg, sum_ang_next;
    logic [psg_pkg::RANGE_W-1:0]      scan_min_reg, scan_min_next;
    logic [psg_pkg::SCAN_IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic                             min_found_reg, min_found_next;
    logic [psg_pkg::SCAN_IDX_W-1:0]   sample_idx_reg, sample_idx_next;
    logic                             backing_reg, backing_next;

    logic                             hist_full;
    logic signed [psg_pkg::SUM_W:0]   lin_acc, ang_acc;
    logic signed [psg_pkg::SUM_W-1:0] sum_lin_new, sum_ang_new;
    logic [psg_pkg::HIST_CNT_W-1:0]   count_new;
    logic                             hit;
    logic [psg_pkg::RANGE_W-1:0]      dist_new;
    logic [psg_pkg::SCAN_IDX_W-1:0]   idx_new;
    logic                             found_new;
    logic [psg_pkg::SECTOR_W-1:0]     n_ext, two_n, idx_p1, sector_t;
    logic [psg_pkg::DIR_W-1:0]        dir_new;
    logic                             backup_enter, backup_exit, backup_after;

    // history update for a user command
    always_comb
    begin
        hist_full = (hist_count_reg == psg_pkg::HIST_CNT_W'(psg_pkg::HIST_DEPTH));
        lin_acc = (psg_pkg::SUM_W+1)'(sum_lin_reg) + (psg_pkg::SUM_W+1)'(linear_vel);
        ang_acc = (psg_pkg::SUM_W+1)'(sum_ang_reg) + (psg_pkg::SUM_W+1)'(angular_vel);
        if (hist_full)
        begin
            lin_acc = lin_acc - (psg_pkg::SUM_W+1)'(hist_lin_reg[hist_pos_reg]);
            ang_acc = ang_acc - (psg_pkg::SUM_W+1)'(hist_ang_reg[hist_pos_reg]);
            count_new = hist_count_reg;
        end
        else
        begin
            count_new = hist_count_reg + 1'b1;
        end
        sum_lin_new = lin_acc[psg_pkg::SUM_W-1:0];
        sum_ang_new = ang_acc[psg_pkg::SUM_W-1:0];
    end

    // nearest sample tracking and sector of the scan
    always_comb
    begin
        hit = (range_sample < scan_min_reg) && (range_sample > cfg.low)
              && (range_sample < cfg.high);
        dist_new  = hit ? range_sample : scan_min_reg;
        idx_new   = hit ? sample_idx_reg : min_idx_reg;
        found_new = hit | min_found_reg;
        n_ext     = psg_pkg::SECTOR_W'(sample_idx_reg) + 1'b1;
        two_n     = n_ext << 1;
        idx_p1    = psg_pkg::SECTOR_W'(idx_new) + 1'b1;
        sector_t  = (idx_p1 << 1) + idx_p1;
        if (!found_new)
            dir_new = psg_pkg::DIR_UNKNOWN;
        else if (sector_t <= n_ext)
            dir_new = psg_pkg::DIR_RIGHT;
        else if (sector_t <= two_n)
            dir_new = psg_pkg::DIR_FRONT;
        else
            dir_new = psg_pkg::DIR_LEFT;
        backup_enter = backing_reg || (dist_new < psg_pkg::RANGE_W'(cfg.thr));
        backup_exit  = backup_enter
                       && (dist_new > (psg_pkg::RANGE_W'(cfg.thr) + psg_pkg::EXIT_MARGIN));
        backup_after = backup_enter && !backup_exit;
    end

    // state next values and job build
    always_comb
    begin
        hist_count_next = hist_count_reg;
        hist_pos_next   = hist_pos_reg;
        sum_lin_next    = sum_lin_reg;
        sum_ang_next    = sum_ang_reg;
        scan_min_next   = scan_min_reg;
        min_idx_next    = min_idx_reg;
        min_found_next  = min_found_reg;
        sample_idx_next = sample_idx_reg;
        backing_next    = backing_reg;
        job_push        = 1'b0;
        job             = '0;
        if (accept)
        begin
            case (cmd)
                psg_pkg::CMD_USER:
                begin
                    hist_count_next = count_new;
                    hist_pos_next   = (hist_pos_reg
                                       == psg_pkg::HIST_IDX_W'(psg_pkg::HIST_DEPTH - 1))
                                      ? '0 : hist_pos_reg + 1'b1;
                    sum_lin_next    = sum_lin_new;
                    sum_ang_next    = sum_ang_new;
                    job_push        = !backing_reg;
                    job.kind        = psg_pkg::KIND_DRIVE;
                    job.drive_lin   = linear_vel;
                    job.drive_ang   = angular_vel;
                    job.sum_lin     = sum_lin_new;
                    job.sum_ang     = sum_ang_new;
                    job.count       = count_new;
                end
                psg_pkg::CMD_RANGE:
                begin
                    if (sample_last)
                    begin
                        scan_min_next   = psg_pkg::NO_RANGE;
                        min_idx_next    = '0;
                        min_found_next  = 1'b0;
                        sample_idx_next = '0;
                        backing_next    = backup_after;
                        job_push        = 1'b1;
                        job.kind        = psg_pkg::KIND_REPORT;
                        job.two         = backup_after;
                        job.near_mm     = dist_new;
                        job.dir         = dir_new;
                        job.thr         = cfg.thr;
                        job.backup      = backup_after;
                        job.sum_lin     = sum_lin_reg;
                        job.sum_ang     = sum_ang_reg;
                        job.count       = hist_count_reg;
                    end
                    else
                    begin
                        scan_min_next  = dist_new;
                        min_idx_next   = idx_new;
                        min_found_next = found_new;
                        if (sample_idx_reg != psg_pkg::SCAN_IDX_W'(psg_pkg::MAX_SCAN_POINTS - 1))
                            sample_idx_next = sample_idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    job_push = 1'b0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_count_reg <= '0;
            hist_pos_reg   <= '0;
            sum_lin_reg    <= '0;
            sum_ang_reg    <= '0;
            scan_min_reg   <= psg_pkg::NO_RANGE;
            min_idx_reg    <= '0;
            min_found_reg  <= 1'b0;
            sample_idx_reg <= '0;
            backing_reg    <= 1'b0;
        end
        else
        begin
            hist_count_reg <= hist_count_next;
            hist_pos_reg   <= hist_pos_next;
            sum_lin_reg    <= sum_lin_next;
            sum_ang_reg    <= sum_ang_next;
            scan_min_reg   <= scan_min_next;
            min_idx_reg    <= min_idx_next;
            min_found_reg  <= min_found_next;
            sample_idx_reg <= sample_idx_next;
            backing_reg    <= backing_next;
        end
    end

    // history entries
    always_ff @(posedge clk)
    begin
        if (accept && (cmd == psg_pkg::CMD_USER))
        begin
            hist_lin_reg[hist_pos_reg] <= linear_vel;
            hist_ang_reg[hist_pos_reg] <= angular_vel;
        end
    end

endmodule
`default_nettype wire

@@ design/psg_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psg_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module psg_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire psg_pkg::job_t job_in,
    output logic               full,
    input  wire logic          pop,
    output psg_pkg::job_t      job_out,
    output logic               empty
);

    psg_pkg::job_t                slot_reg [psg_pkg::QUEUE_DEPTH];
    logic [psg_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [psg_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [psg_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic                         do_push, do_pop;

    // occupancy and pointers
    always_comb
    begin
        full    = (count_reg == psg_pkg::QUEUE_CW'(psg_pkg::QUEUE_DEPTH));
        empty   = (count_reg == '0);
        do_push = push && !full;
        do_pop  = pop && !empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
        job_out = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= job_in;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= psg_pkg::QUEUE_CW'(psg_pkg::QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed while queue full");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue push lost");
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue pop lost");

endmodule
`default_nettype wire

@@ design/psg_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psg_back
// Takes jobs from the queue, works out the history means and presents the
// one or two result words of each job.
// ----------------------------------------------------------------------------
module psg_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire psg_pkg::job_t job_in,
    input  wire logic          job_empty,
    output logic               job_pop,
    output psg_pkg::result_t   result,
    output logic               empty,
    input  wire logic          pop
);

    psg_pkg::back_state_t state_reg, state_next;
    psg_pkg::job_t        job_reg;
    logic [psg_pkg::PROD_W-1:0] prod_lin_reg, prod_ang_reg;
    logic                       neg_lin_reg, neg_ang_reg;

    logic signed [psg_pkg::SUM_W-1:0] neg_sum_lin, neg_sum_ang;
    logic [psg_pkg::ABS_W-1:0]        abs_lin, abs_ang;
    logic [psg_pkg::RECIP_W-1:0]      rcp;
    logic [psg_pkg::QUOT_W-1:0]       quot_lin, quot_ang;
    logic [psg_pkg::QUOT_W-1:0]       sq_lin, sq_ang;
    logic signed [psg_pkg::VEL_W-1:0] avg_lin, avg_ang;

    // magnitudes and reciprocal of the count
    always_comb
    begin
        neg_sum_lin = -job_reg.sum_lin;
        neg_sum_ang = -job_reg.sum_ang;
        abs_lin = job_reg.sum_lin[psg_pkg::SUM_W-1] ? neg_sum_lin[psg_pkg::ABS_W-1:0]
                                                    : job_reg.sum_lin[psg_pkg::ABS_W-1:0];
        abs_ang = job_reg.sum_ang[psg_pkg::SUM_W-1] ? neg_sum_ang[psg_pkg::ABS_W-1:0]
                                                    : job_reg.sum_ang[psg_pkg::ABS_W-1:0];
        rcp = psg_pkg::recip(job_reg.count);
    end

    // quotient with sign restored, truncated toward zero
    always_comb
    begin
        quot_lin = prod_lin_reg[psg_pkg::RECIP_SHIFT +: psg_pkg::QUOT_W];
        quot_ang = prod_ang_reg[psg_pkg::RECIP_SHIFT +: psg_pkg::QUOT_W];
        sq_lin   = neg_lin_reg ? -quot_lin : quot_lin;
        sq_ang   = neg_ang_reg ? -quot_ang : quot_ang;
        avg_lin  = sq_lin[psg_pkg::VEL_W-1:0];
        avg_ang  = sq_ang[psg_pkg::VEL_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psg_pkg::BK_IDLE:
                if (!job_empty)
                    state_next = psg_pkg::BK_CALC;
            psg_pkg::BK_CALC:
                state_next = psg_pkg::BK_FIRST;
            psg_pkg::BK_FIRST:
                if (pop)
                    state_next = job_reg.two ? psg_pkg::BK_SECOND : psg_pkg::BK_IDLE;
            psg_pkg::BK_SECOND:
                if (pop)
                    state_next = psg_pkg::BK_IDLE;
            default:
                state_next = psg_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        job_pop = 1'b0;
        empty   = 1'b1;
        result  = '0;
        result.avg_valid    = (job_reg.count != '0);
        result.mean_linear  = avg_lin;
        result.mean_angular = avg_ang;
        case (state_reg)
            psg_pkg::BK_IDLE:
                job_pop = !job_empty;
            psg_pkg::BK_CALC:
                job_pop = 1'b0;
            psg_pkg::BK_FIRST:
            begin
                empty                = 1'b0;
                result.kind          = job_reg.kind;
                result.drive_linear  = job_reg.drive_lin;
                result.drive_angular = job_reg.drive_ang;
                result.near_distance = job_reg.near_mm;
                result.direction     = job_reg.dir;
                result.threshold_now = job_reg.thr;
                result.backup_active = job_reg.backup;
                result.last          = !job_reg.two;
            end
            psg_pkg::BK_SECOND:
            begin
                empty                = 1'b0;
                result.kind          = psg_pkg::KIND_DRIVE;
                result.drive_linear  = (job_reg.dir == psg_pkg::DIR_FRONT)
                                       ? psg_pkg::REVERSE_SPEED : '0;
                result.is_override   = 1'b1;
                result.backup_active = job_reg.backup;
                result.last          = 1'b1;
            end
            default:
                empty = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= psg_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // job capture and products
    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job_in;
        if (state_reg == psg_pkg::BK_CALC)
        begin
            prod_lin_reg <= psg_pkg::PROD_W'(abs_lin) * psg_pkg::PROD_W'(rcp);
            prod_ang_reg <= psg_pkg::PROD_W'(abs_ang) * psg_pkg::PROD_W'(rcp);
            neg_lin_reg  <= job_reg.sum_lin[psg_pkg::SUM_W-1];
            neg_ang_reg  <= job_reg.sum_ang[psg_pkg::SUM_W-1];
        end
    end

endmodule
`default_nettype wire

@@ design/proximity_safety_gate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// proximity_safety_gate
// Safety gate between user velocity commands and the wheels, driven by a
// laser range scan.
// ----------------------------------------------------------------------------
// Usage
//   Input side: a word is taken on a clock edge with push high and full low.
//   cmd low carries a user command (linear_vel, angular_vel), cmd high one
//   range sample, sample_last marking the end of a scan.
//   Result side: while empty is low the oldest result is on the result ports;
//   it is taken on an edge with pop high. A scan end gives a state report and,
//   in backup, an override drive word; a user command gives a drive word
//   unless backup holds; other words give nothing.
//   A result shows after its job has passed the queue and the CALC state.
//   Throughput: the front takes one word per cycle while its four-entry job
//   queue has room. The back handles one job at a time: it fetches the job,
//   does the mean multiply and then presents each result word until it is
//   popped, and fetches the next job only after the last word is popped.
//   A stalled receiver holds the result; the queue fills and then full rises.
//   Reset clears history, scan tracking, backup mode and the queue; the
//   registers return to threshold 1000, range limits 100 and 30000.
//   Registers: threshold at 0x0, lower limit at 0x4, upper limit at 0x8.
// ----------------------------------------------------------------------------
module proximity_safety_gate (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [psg_pkg::APB_AW-1:0]        paddr,
    input  wire logic [psg_pkg::APB_DW-1:0]        pwdata,
    output logic [psg_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready,
    // input words
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              cmd,
    input  wire logic signed [psg_pkg::VEL_W-1:0]  linear_vel,
    input  wire logic signed [psg_pkg::VEL_W-1:0]  angular_vel,
    input  wire logic [psg_pkg::RANGE_W-1:0]       range_sample,
    input  wire logic                              sample_last,
    // result words
    output logic                                   empty,
    input  wire logic                              pop,
    output logic                                   kind,
    output logic signed [psg_pkg::VEL_W-1:0]       drive_linear,
    output logic signed [psg_pkg::VEL_W-1:0]       drive_angular,
    output logic                                   is_override,
    output logic [psg_pkg::RANGE_W-1:0]            near_distance,
    output logic [psg_pkg::DIR_W-1:0]              direction,
    output logic [psg_pkg::THR_W-1:0]              threshold_now,
    output logic                                   backup_active,
    output logic                                   avg_valid,
    output logic signed [psg_pkg::VEL_W-1:0]       mean_linear,
    output logic signed [psg_pkg::VEL_W-1:0]       mean_angular,
    output logic                                   last
);

    logic [psg_pkg::THR_W-1:0]     thr_reg;
    logic [psg_pkg::RANGE_W-1:0]   low_reg, high_reg;
    logic [psg_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;
    psg_pkg::cfg_t                 cfg;
    psg_pkg::job_t                 front_job, queue_job;
    logic                          job_push, job_pop, queue_empty, queue_full;
    logic                          accept;
    psg_pkg::result_t              result;

    // register access
    assign pready    = 1'b1;
    assign reg_idx   = paddr[psg_pkg::APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            psg_pkg::REG_THRESHOLD:  prdata = psg_pkg::APB_DW'(thr_reg);
            psg_pkg::REG_RANGE_LOW:  prdata = psg_pkg::APB_DW'(low_reg);
            psg_pkg::REG_RANGE_HIGH: prdata = psg_pkg::APB_DW'(high_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= psg_pkg::THRESHOLD_RESET;
            low_reg  <= psg_pkg::RANGE_LOW_RESET;
            high_reg <= psg_pkg::RANGE_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                psg_pkg::REG_THRESHOLD:  thr_reg  <= pwdata[psg_pkg::THR_W-1:0];
                psg_pkg::REG_RANGE_LOW:  low_reg  <= pwdata[psg_pkg::RANGE_W-1:0];
                psg_pkg::REG_RANGE_HIGH: high_reg <= pwdata[psg_pkg::RANGE_W-1:0];
                default:                 thr_reg  <= thr_reg;
            endcase
        end
    end

    assign cfg.thr  = thr_reg;
    assign cfg.low  = low_reg;
    assign cfg.high = high_reg;

    // input word handshake
    assign full   = queue_full;
    assign accept = push && !queue_full;

    psg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .linear_vel   (linear_vel),
        .angular_vel  (angular_vel),
        .range_sample (range_sample),
        .sample_last  (sample_last),
        .cfg          (cfg),
        .job          (front_job),
        .job_push     (job_push)
    );

    psg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (front_job),
        .full    (queue_full),
        .pop     (job_pop),
        .job_out (queue_job),
        .empty   (queue_empty)
    );

    psg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_in    (queue_job),
        .job_empty (queue_empty),
        .job_pop   (job_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    // result fields
    assign kind          = result.kind;
    assign drive_linear  = result.drive_linear;
    assign drive_angular = result.drive_angular;
    assign is_override   = result.is_override;
    assign near_distance = result.near_distance;
    assign direction     = result.direction;
    assign threshold_now = result.threshold_now;
    assign backup_active = result.backup_active;
    assign avg_valid     = result.avg_valid;
    assign mean_linear   = result.mean_linear;
    assign mean_angular  = result.mean_angular;
    assign last          = result.last;

endmodule
`default_nettype wire
